// ===== hw/rtl/adfp_pkg.sv =====
package adfp_pkg;

   localparam int MAX_VALUE_CHARS  = 16;
   localparam int MIN_BUFFER_BYTES = 5;
   localparam int FRACTION_DIGITS  = 3;

   localparam int UNIT_SCALE      = 10 ** FRACTION_DIGITS;
   localparam int LENGTH_BITS     = $clog2(MAX_VALUE_CHARS + 1);
   localparam int COUNT_BITS      = $clog2(MIN_BUFFER_BYTES + 1);
   localparam int FRAC_COUNT_BITS = $clog2(FRACTION_DIGITS + 1);
   localparam int FRAC_BITS       = $clog2(UNIT_SCALE);
   localparam int SCALE_BITS      = $clog2(UNIT_SCALE + 1);

   localparam logic [31:0] MAG_LIMIT     = 32'h7FFF_FFFF;
   localparam logic [31:0] INT_LIMIT_HI  = MAG_LIMIT / 10;
   localparam logic [3:0]  INT_LIMIT_REM = 4'(MAG_LIMIT % 10);
   localparam logic [31:0] INT_SAT_LIMIT = MAG_LIMIT / UNIT_SCALE;
   localparam int          INT_PROD_BITS = $clog2(INT_SAT_LIMIT + 1);

   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef enum logic [1:0] {
      PHASE_SEARCH  = 2'd0,
      PHASE_COLLECT = 2'd1,
      PHASE_DONE    = 2'd2
   } phase_type;

   typedef struct packed {
      logic                       ok;
      logic                       negative;
      logic                       overflow;
      logic [31:0]                int_acc;
      logic [FRAC_BITS-1:0]       frac_acc;
      logic [FRAC_COUNT_BITS-1:0] frac_count;
   } frame_info_type;

   function automatic logic [SCALE_BITS-1:0] fraction_scale(
      input logic [FRAC_COUNT_BITS-1:0] count
   );
      logic [SCALE_BITS-1:0] s;
      s = SCALE_BITS'(1);
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
         if (i >= int'(count)) begin
            s = SCALE_BITS'(s * SCALE_BITS'(10));
         end
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/ascii_decimal_frame_parser.sv =====
// Parses framed ASCII decimal numbers ("#<text>$") from a byte stream.
// Request channel (req_): one word per cycle while req_stall is low. req_action selects a byte
// delivery or a read of the held position; req_last_byte marks the end of
// a receive buffer. Bytes that are not last give no response word.
// Response channel (rsp_): one word for each read and each buffer end,
// carrying the frame verdict, the parsed value in thousandths, the
// saturation flag, the held position and the fresh flag.
// Throughput is one request word per cycle unless req_stall is high; the
// per-byte multiply-by-ten and add of the parse state sets that rate. A
// response word passes through the input register, the finalize stage
// with the scaling multiply and the output register.
// Reset clears the parse state, the held position and the fresh flag.
// When the receiver holds rsp_stall, the output word holds, the finalize
// stage fills, and req_stall rises only once a result-bearing word cannot
// move on; plain bytes keep flowing into the parser until then.
module ascii_decimal_frame_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_ok,
   output logic signed [31:0] rsp_frame_value,
   output logic               rsp_saturated,
   output logic signed [31:0] rsp_held_position,
   output logic               rsp_fresh
);
   import adfp_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic        a_action_ff;
   logic [7:0]  a_byte_ff;
   logic        a_last_ff;
   logic        a_result;
   logic        a_fire;
   logic        a_step;

   logic           b_valid_ff, b_valid_in;
   logic           b_read_ff;
   frame_info_type b_info_ff;
   frame_info_type parse_info;
   logic           b_fire;
   logic           b_free;

   logic        o_free;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff;
   logic [31:0] value_ff;
   logic        sat_ff;
   logic [31:0] held_out_ff;
   logic        fresh_out_ff;

   logic [31:0] store_ff, store_in;
   logic        fresh_ff, fresh_in;

   logic [31:0] int_scaled;
   logic [31:0] frac_scaled;
   logic [31:0] mag_sum;
   logic        int_big;
   logic        sat;
   logic [31:0] mag;
   logic [31:0] value;
   logic        ok_out;
   logic [31:0] value_out;
   logic        sat_out;
   logic [31:0] held_out;
   logic        fresh_out;

   assign o_free   = !rsp_valid_ff || !rsp_stall;
   assign b_fire   = b_valid_ff && o_free;
   assign b_free   = !b_valid_ff || o_free;
   assign a_result = (a_action_ff == ACTION_READ) || a_last_ff;
   assign a_fire   = a_valid_ff && (!a_result || b_free);
   assign a_step   = a_fire && (a_action_ff == ACTION_BYTE);

   assign req_stall    = a_valid_ff && !a_fire;
   assign a_valid_in   = (req_valid && !req_stall) || (a_valid_ff && !a_fire);
   assign b_valid_in   = (a_fire && a_result) || (b_valid_ff && !b_fire);
   assign rsp_valid_in = b_fire || (rsp_valid_ff && rsp_stall);

   adfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (a_step),
      .data_byte (a_byte_ff),
      .last_byte (a_last_ff),
      .info      (parse_info)
   );

   assign int_big     = b_info_ff.overflow || (b_info_ff.int_acc > INT_SAT_LIMIT);
   assign int_scaled  = 32'(b_info_ff.int_acc[INT_PROD_BITS-1:0]) * 32'(UNIT_SCALE);
   assign frac_scaled = 32'(b_info_ff.frac_acc) * 32'(fraction_scale(b_info_ff.frac_count));
   assign mag_sum     = int_scaled + frac_scaled;
   assign sat         = int_big || (mag_sum > MAG_LIMIT);
   assign mag         = sat ? MAG_LIMIT : mag_sum;
   assign value       = b_info_ff.negative ? (32'd0 - mag) : mag;

   always_comb begin
      store_in  = store_ff;
      fresh_in  = fresh_ff;
      ok_out    = 1'b0;
      value_out = '0;
      sat_out   = 1'b0;
      held_out  = store_ff;
      fresh_out = fresh_ff;
      if (b_read_ff) begin
         fresh_in = 1'b0;
      end else begin
         if (b_info_ff.ok) begin
            store_in  = value;
            fresh_in  = 1'b1;
            ok_out    = 1'b1;
            value_out = value;
            sat_out   = sat;
         end
         held_out  = store_in;
         fresh_out = fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         store_ff     <= '0;
         fresh_ff     <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_fire) begin
            store_ff <= store_in;
            fresh_ff <= fresh_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_action_ff <= req_action;
         a_byte_ff   <= req_data_byte;
         a_last_ff   <= req_last_byte;
      end
      if (a_fire && a_result) begin
         b_read_ff <= (a_action_ff == ACTION_READ);
         b_info_ff <= parse_info;
      end
      if (b_fire) begin
         ok_ff        <= ok_out;
         value_ff     <= value_out;
         sat_ff       <= sat_out;
         held_out_ff  <= held_out;
         fresh_out_ff <= fresh_out;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_ok      = ok_ff;
   assign rsp_frame_value   = value_ff;
   assign rsp_saturated     = sat_ff;
   assign rsp_held_position = held_out_ff;
   assign rsp_fresh         = fresh_out_ff;

   a_bad_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |-> (rsp_frame_value == 32'sd0) && !rsp_saturated)
      else $error("value or saturation reported on a frame that failed");

   a_ok_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> (rsp_held_position == rsp_frame_value) && rsp_fresh)
      else $error("good frame did not update held position and fresh flag");

   a_read_clears : assert property (@(posedge clock) disable iff (reset)
      b_fire && b_read_ff |=> !fresh_ff)
      else $error("fresh flag survived a read");

   a_no_lost_word : assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_fire |=> b_valid_ff)
      else $error("finalize stage dropped a word");

endmodule

// ===== hw/rtl/adfp_parse.sv =====
module adfp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output adfp_pkg::frame_info_type info
);
   import adfp_pkg::*;

   phase_type                  phase_ff, phase_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [LENGTH_BITS-1:0]     length_ff, length_in;
   logic                       negative_ff, negative_in;
   logic                       dot_ff, dot_in;
   logic                       digit_ff, digit_in;
   logic                       error_ff, error_in;
   logic [31:0]                int_ff, int_in;
   logic                       overflow_ff, overflow_in;
   logic [FRAC_BITS-1:0]       frac_ff, frac_in;
   logic [FRAC_COUNT_BITS-1:0] frac_count_ff, frac_count_in;

   logic [3:0]  digit;
   logic [31:0] int_limit;
   logic        is_digit;

   assign digit     = 4'(data_byte - CHAR_ZERO);
   assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign int_limit = (digit > INT_LIMIT_REM) ? (INT_LIMIT_HI - 32'd1) : INT_LIMIT_HI;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      length_in     = length_ff;
      negative_in   = negative_ff;
      dot_in        = dot_ff;
      digit_in      = digit_ff;
      error_in      = error_ff;
      int_in        = int_ff;
      overflow_in   = overflow_ff;
      frac_in       = frac_ff;
      frac_count_in = frac_count_ff;

      if (count_ff < COUNT_BITS'(MIN_BUFFER_BYTES)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end

      case (phase_ff)
         PHASE_SEARCH: begin
            if (data_byte == CHAR_HASH) begin
               phase_in = PHASE_COLLECT;
            end
         end
         PHASE_COLLECT: begin
            if (data_byte == CHAR_DOLLAR) begin
               phase_in = PHASE_DONE;
            end else if (length_ff >= LENGTH_BITS'(MAX_VALUE_CHARS)) begin
               error_in = 1'b1;
            end else begin
               length_in = length_ff + LENGTH_BITS'(1);
               if ((length_ff == '0) &&
                   ((data_byte == CHAR_MINUS) || (data_byte == CHAR_PLUS))) begin
                  negative_in = (data_byte == CHAR_MINUS);
               end else if (data_byte == CHAR_DOT) begin
                  if (dot_ff) begin
                     error_in = 1'b1;
                  end
                  dot_in = 1'b1;
               end else if (is_digit) begin
                  digit_in = 1'b1;
                  if (!dot_ff) begin
                     if (overflow_ff || (int_ff > int_limit)) begin
                        overflow_in = 1'b1;
                        int_in      = MAG_LIMIT;
                     end else begin
                        int_in = (int_ff << 3) + (int_ff << 1) + 32'(digit);
                     end
                  end else if (int'(frac_count_ff) < FRACTION_DIGITS) begin
                     frac_in       = FRAC_BITS'((frac_ff << 3) + (frac_ff << 1)
                                                + FRAC_BITS'(digit));
                     frac_count_in = frac_count_ff + FRAC_COUNT_BITS'(1);
                  end
               end else begin
                  error_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      info.ok         = (phase_in == PHASE_DONE) && !error_in && digit_in &&
                        (count_in >= COUNT_BITS'(MIN_BUFFER_BYTES));
      info.negative   = negative_in;
      info.overflow   = overflow_in;
      info.int_acc    = int_in;
      info.frac_acc   = frac_in;
      info.frac_count = frac_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff      <= PHASE_SEARCH;
         count_ff      <= '0;
         length_ff     <= '0;
         negative_ff   <= 1'b0;
         dot_ff        <= 1'b0;
         digit_ff      <= 1'b0;
         error_ff      <= 1'b0;
         int_ff        <= '0;
         overflow_ff   <= 1'b0;
         frac_ff       <= '0;
         frac_count_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         length_ff     <= length_in;
         negative_ff   <= negative_in;
         dot_ff        <= dot_in;
         digit_ff      <= digit_in;
         error_ff      <= error_in;
         int_ff        <= int_in;
         overflow_ff   <= overflow_in;
         frac_ff       <= frac_in;
         frac_count_ff <= frac_count_in;
      end
   end

endmodule
